FILE: rtl/erot_pkg.sv
// Shared constants, types and tables of the Euler point rotator.
// Holds the CORDIC arctangent table and the coefficient build sequence.
// Depends on nothing.
`default_nettype none
package erot_pkg;

    localparam int COORD_WIDTH_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int ANGLE_WIDTH_DEF    = 16;

    localparam int TURN_WIDTH   = 32;
    localparam int TRIG_WIDTH   = 32;
    localparam int CORDIC_WIDTH = 34;
    localparam int ZRES_WIDTH   = 33;
    localparam int PROD_WIDTH   = 64;
    localparam int ACC_WIDTH    = 66;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_COUNT   = 15;
    localparam int FIFO_DEPTH   = 4;
    localparam int REG_COUNT    = 3;
    localparam int COEF_COUNT   = 9;

    localparam logic signed [TRIG_WIDTH-1:0] CORDIC_ONE = 32'sd652032874;
    localparam logic signed [TRIG_WIDTH-1:0] Q30_ONE    = 32'sd1073741824;

    localparam logic [1:0] REG_FIRST_SPIN = 2'd0;
    localparam logic [1:0] REG_TILT       = 2'd1;
    localparam logic [1:0] REG_LAST_SPIN  = 2'd2;

    localparam logic [3:0] OPD_CP  = 4'd0;
    localparam logic [3:0] OPD_SP  = 4'd1;
    localparam logic [3:0] OPD_CT  = 4'd2;
    localparam logic [3:0] OPD_ST  = 4'd3;
    localparam logic [3:0] OPD_CS  = 4'd4;
    localparam logic [3:0] OPD_SS  = 4'd5;
    localparam logic [3:0] OPD_SCT = 4'd6;
    localparam logic [3:0] OPD_CCT = 4'd7;
    localparam logic [3:0] OPD_ONE = 4'd8;

    localparam logic [3:0] DST_SCT = 4'd9;
    localparam logic [3:0] DST_CCT = 4'd10;

    typedef struct packed {
        logic [3:0] sel_a;
        logic [3:0] sel_b;
        logic       neg;
        logic       first;
        logic       last;
        logic [3:0] dest;
    } mstep_t;

    function automatic mstep_t mstep(input logic [3:0] idx);
        mstep_t s;
        s = '0;
        unique case (idx)
            4'd0:    s = '{OPD_SS,  OPD_CT,  1'b0, 1'b1, 1'b1, DST_SCT};
            4'd1:    s = '{OPD_CS,  OPD_CT,  1'b0, 1'b1, 1'b1, DST_CCT};
            4'd2:    s = '{OPD_CS,  OPD_CP,  1'b0, 1'b1, 1'b0, 4'd0};
            4'd3:    s = '{OPD_SCT, OPD_SP,  1'b1, 1'b0, 1'b1, 4'd0};
            4'd4:    s = '{OPD_CS,  OPD_SP,  1'b1, 1'b1, 1'b0, 4'd1};
            4'd5:    s = '{OPD_SCT, OPD_CP,  1'b1, 1'b0, 1'b1, 4'd1};
            4'd6:    s = '{OPD_SS,  OPD_ST,  1'b0, 1'b1, 1'b1, 4'd2};
            4'd7:    s = '{OPD_SS,  OPD_CP,  1'b0, 1'b1, 1'b0, 4'd3};
            4'd8:    s = '{OPD_CCT, OPD_SP,  1'b0, 1'b0, 1'b1, 4'd3};
            4'd9:    s = '{OPD_SS,  OPD_SP,  1'b1, 1'b1, 1'b0, 4'd4};
            4'd10:   s = '{OPD_CCT, OPD_CP,  1'b0, 1'b0, 1'b1, 4'd4};
            4'd11:   s = '{OPD_CS,  OPD_ST,  1'b1, 1'b1, 1'b1, 4'd5};
            4'd12:   s = '{OPD_ST,  OPD_SP,  1'b0, 1'b1, 1'b1, 4'd6};
            4'd13:   s = '{OPD_ST,  OPD_CP,  1'b0, 1'b1, 1'b1, 4'd7};
            4'd14:   s = '{OPD_CT,  OPD_ONE, 1'b0, 1'b1, 1'b1, 4'd8};
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] t;
        t = '0;
        case (i)
            5'd0:  t = 32'd536870912;
            5'd1:  t = 32'd316933406;
            5'd2:  t = 32'd167458907;
            5'd3:  t = 32'd85004756;
            5'd4:  t = 32'd42667331;
            5'd5:  t = 32'd21354465;
            5'd6:  t = 32'd10679838;
            5'd7:  t = 32'd5340245;
            5'd8:  t = 32'd2670163;
            5'd9:  t = 32'd1335087;
            5'd10: t = 32'd667544;
            5'd11: t = 32'd333772;
            5'd12: t = 32'd166886;
            5'd13: t = 32'd83443;
            5'd14: t = 32'd41722;
            5'd15: t = 32'd20861;
            5'd16: t = 32'd10430;
            5'd17: t = 32'd5215;
            5'd18: t = 32'd2608;
            5'd19: t = 32'd1304;
            5'd20: t = 32'd652;
            5'd21: t = 32'd326;
            5'd22: t = 32'd163;
            5'd23: t = 32'd81;
            5'd24: t = 32'd41;
            5'd25: t = 32'd20;
            5'd26: t = 32'd10;
            5'd27: t = 32'd5;
            5'd28: t = 32'd3;
            5'd29: t = 32'd1;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/euler_point_rotator_top.sv
// Top level of the ZXZ Euler point rotator: front gate, queue, back end, coefficient builder.
// Depends on erot_pkg, erot_coef, erot_fifo and erot_mac.
//
// Channel  Direction  Handshake          Payload
// s_       in         s_tvalid/s_tready  s_tdata: point_x, point_y, point_z
// m_       out        m_tvalid/m_tready  m_tdata: rotated_x/y/z; m_tuser: clipped
// cfg_     in         cfg_wr_en          cfg_addr: register index, cfg_wdata: angle
//
// One point per cycle sustained while m_ is not stalled and no rebuild runs.
// After reset and after every angle write the matrix is rebuilt in three CORDIC passes,
// then fifteen multiply steps; s_tready is low during the rebuild.
// A stall on m_ holds the three back stages; the four-entry queue absorbs items in flight.
`default_nettype none
module euler_point_rotator_top
    import erot_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
    localparam int CFW           = COEF_FRAC_BITS + 2,
    localparam int PT_W          = 3 * COORD_WIDTH,
    localparam int TDATA_W       = ((PT_W + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [TDATA_W-1:0]     s_tdata,   // point_x, point_y, point_z, zero pad
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_W-1:0]          m_tdata,   // rotated_x, rotated_y, rotated_z, zero pad
    output logic                        m_tuser,   // clipped
    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_addr,
    input  wire logic [ANGLE_WIDTH-1:0] cfg_wdata
);

    logic                         coef_busy;
    logic [COEF_COUNT*CFW-1:0]    coefs;
    logic                         q_full, q_valid, q_pop, push;
    logic [PT_W-1:0]              q_head, res;

    assign s_tready = !coef_busy && !q_full;
    assign push     = s_tvalid && s_tready;

    erot_coef #(
        .ANGLE_WIDTH    (ANGLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .busy      (coef_busy),
        .coefs     (coefs)
    );

    erot_fifo #(
        .WIDTH (PT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (s_tdata[PT_W-1:0]),
        .pop       (q_pop),
        .head_data (q_head),
        .full      (q_full),
        .not_empty (q_valid)
    );

    erot_mac #(
        .COORD_WIDTH    (COORD_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .coefs       (coefs),
        .in_valid    (q_valid),
        .in_data     (q_head),
        .in_pop      (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (res),
        .out_clipped (m_tuser)
    );

    assign m_tdata = TDATA_W'(res);

endmodule
`default_nettype wire

FILE: rtl/erot_coef.sv
// Angle registers and rotation coefficient builder.
// One shared CORDIC unit for three angles, then one shared multiplier for nine coefficients and two helper terms.
// Depends on erot_pkg.
`default_nettype none
module erot_coef
    import erot_pkg::*;
#(
    parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int CFW           = COEF_FRAC_BITS + 2
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [1:0]                  cfg_addr,
    input  wire logic [ANGLE_WIDTH-1:0]      cfg_wdata,
    output logic                             busy,
    output logic [COEF_COUNT*CFW-1:0]        coefs
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_ROT  = 2'd2;
    localparam logic [1:0] ST_MAT  = 2'd3;

    localparam logic signed [ACC_WIDTH-1:0] HALF_Q30 = ACC_WIDTH'(1) <<< 29;
    localparam logic signed [ACC_WIDTH-1:0] HALF_C   = ACC_WIDTH'(1) <<< (59 - COEF_FRAC_BITS);
    localparam logic signed [ACC_WIDTH-1:0] ONE_C    = ACC_WIDTH'(1) <<< COEF_FRAC_BITS;

    logic [1:0]                     state_reg, state_next;
    logic [1:0]                     ang_sel_reg, ang_sel_next;
    logic [4:0]                     iter_reg, iter_next;
    logic [3:0]                     step_reg, step_next;
    logic                           phase_reg, phase_next;
    logic [ANGLE_WIDTH-1:0]         angle_reg [REG_COUNT];
    logic [ANGLE_WIDTH-1:0]         angle_next [REG_COUNT];
    logic signed [CORDIC_WIDTH-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZRES_WIDTH-1:0]   z_reg, z_next;
    logic [1:0]                     quad_reg, quad_next;
    logic signed [TRIG_WIDTH-1:0]   trig_reg [6];
    logic signed [TRIG_WIDTH-1:0]   trig_next [6];
    logic signed [TRIG_WIDTH-1:0]   sct_reg, sct_next, cct_reg, cct_next;
    logic signed [PROD_WIDTH-1:0]   prod_reg, prod_next;
    logic signed [ACC_WIDTH-1:0]    acc_reg, acc_next;
    logic signed [CFW-1:0]          coef_reg [COEF_COUNT];
    logic signed [CFW-1:0]          coef_next [COEF_COUNT];

    logic [TURN_WIDTH-1:0]          turn;
    logic signed [CORDIC_WIDTH-1:0] dx, dy, xr, yr, cos_v, sin_v;
    logic signed [ZRES_WIDTH-1:0]   at, zr;
    mstep_t                         st;
    logic signed [TRIG_WIDTH-1:0]   op_a, op_b;
    logic signed [ACC_WIDTH-1:0]    term, sum, rnd30, rndc, clampc;

    function automatic logic signed [TRIG_WIDTH-1:0] operand(
        input logic [3:0] sel,
        input logic signed [TRIG_WIDTH-1:0] t0, input logic signed [TRIG_WIDTH-1:0] t1,
        input logic signed [TRIG_WIDTH-1:0] t2, input logic signed [TRIG_WIDTH-1:0] t3,
        input logic signed [TRIG_WIDTH-1:0] t4, input logic signed [TRIG_WIDTH-1:0] t5,
        input logic signed [TRIG_WIDTH-1:0] a6, input logic signed [TRIG_WIDTH-1:0] a7);
        logic signed [TRIG_WIDTH-1:0] v;
        v = Q30_ONE;
        unique case (sel)
            OPD_CP:  v = t0;
            OPD_SP:  v = t1;
            OPD_CT:  v = t2;
            OPD_ST:  v = t3;
            OPD_CS:  v = t4;
            OPD_SS:  v = t5;
            OPD_SCT: v = a6;
            OPD_CCT: v = a7;
            default: v = Q30_ONE;
        endcase
        return v;
    endfunction

    assign busy = (state_reg != ST_IDLE);
    assign turn = {angle_reg[ang_sel_reg], {(TURN_WIDTH-ANGLE_WIDTH){1'b0}}};

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = ZRES_WIDTH'(atan_turn(iter_reg));
    assign xr = z_reg[ZRES_WIDTH-1] ? x_reg + dx : x_reg - dx;
    assign yr = z_reg[ZRES_WIDTH-1] ? y_reg - dy : y_reg + dy;
    assign zr = z_reg[ZRES_WIDTH-1] ? z_reg + at : z_reg - at;

    always_comb begin
        case (quad_reg)
            2'd0:    begin cos_v = xr;  sin_v = yr;  end
            2'd1:    begin cos_v = -yr; sin_v = xr;  end
            2'd2:    begin cos_v = -xr; sin_v = -yr; end
            default: begin cos_v = yr;  sin_v = -xr; end
        endcase
    end

    assign st   = mstep(step_reg);
    assign op_a = operand(st.sel_a, trig_reg[0], trig_reg[1], trig_reg[2], trig_reg[3],
                          trig_reg[4], trig_reg[5], sct_reg, cct_reg);
    assign op_b = operand(st.sel_b, trig_reg[0], trig_reg[1], trig_reg[2], trig_reg[3],
                          trig_reg[4], trig_reg[5], sct_reg, cct_reg);
    assign term  = st.neg ? -ACC_WIDTH'(prod_reg) : ACC_WIDTH'(prod_reg);
    assign sum   = (st.first ? '0 : acc_reg) + term;
    assign rnd30 = (sum + HALF_Q30) >>> 30;
    assign rndc  = (sum + HALF_C) >>> (60 - COEF_FRAC_BITS);
    assign clampc = (rndc > ONE_C) ? ONE_C : ((rndc < -ONE_C) ? -ONE_C : rndc);

    always_comb begin
        state_next   = state_reg;
        ang_sel_next = ang_sel_reg;
        iter_next    = iter_reg;
        step_next    = step_reg;
        phase_next   = phase_reg;
        angle_next   = angle_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        quad_next    = quad_reg;
        trig_next    = trig_reg;
        sct_next     = sct_reg;
        cct_next     = cct_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        coef_next    = coef_reg;
        unique case (state_reg)
            ST_LOAD: begin
                x_next     = CORDIC_WIDTH'(CORDIC_ONE);
                y_next     = '0;
                z_next     = {3'b000, turn[29:0]};
                quad_next  = turn[31:30];
                iter_next  = '0;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                x_next    = xr;
                y_next    = yr;
                z_next    = zr;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(CORDIC_STEPS - 1)) begin
                    trig_next[{ang_sel_reg, 1'b0}] = TRIG_WIDTH'(cos_v);
                    trig_next[{ang_sel_reg, 1'b1}] = TRIG_WIDTH'(sin_v);
                    if (ang_sel_reg == REG_LAST_SPIN) begin
                        state_next = ST_MAT;
                        step_next  = '0;
                        phase_next = 1'b0;
                    end else begin
                        ang_sel_next = ang_sel_reg + 2'd1;
                        state_next   = ST_LOAD;
                    end
                end
            end
            ST_MAT: begin
                if (!phase_reg) begin
                    prod_next  = op_a * op_b;
                    phase_next = 1'b1;
                end else begin
                    acc_next   = sum;
                    phase_next = 1'b0;
                    if (st.last) begin
                        if (st.dest == DST_SCT) sct_next = TRIG_WIDTH'(rnd30);
                        if (st.dest == DST_CCT) cct_next = TRIG_WIDTH'(rnd30);
                        for (int k = 0; k < COEF_COUNT; k++) begin
                            if (st.dest == 4'(k)) coef_next[k] = CFW'(clampc);
                        end
                    end
                    if (step_reg == 4'(STEP_COUNT - 1)) state_next = ST_IDLE;
                    else step_next = step_reg + 4'd1;
                end
            end
            default: ;
        endcase
        if (cfg_wr_en && (cfg_addr == REG_FIRST_SPIN || cfg_addr == REG_TILT ||
                          cfg_addr == REG_LAST_SPIN)) begin
            angle_next[cfg_addr] = cfg_wdata;
            state_next           = ST_LOAD;
            ang_sel_next         = REG_FIRST_SPIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            ang_sel_reg <= REG_FIRST_SPIN;
            iter_reg    <= '0;
            step_reg    <= '0;
            phase_reg   <= 1'b0;
            for (int k = 0; k < REG_COUNT; k++) angle_reg[k] <= '0;
        end else begin
            state_reg   <= state_next;
            ang_sel_reg <= ang_sel_next;
            iter_reg    <= iter_next;
            step_reg    <= step_next;
            phase_reg   <= phase_next;
            angle_reg   <= angle_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
        trig_reg <= trig_next;
        sct_reg  <= sct_next;
        cct_reg  <= cct_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        coef_reg <= coef_next;
    end

    for (genvar k = 0; k < COEF_COUNT; k++) begin : g_coef_out
        assign coefs[k*CFW +: CFW] = coef_reg[k];
    end

endmodule
`default_nettype wire

FILE: rtl/erot_fifo.sv
// Short queue between the accepting front and the multiply back end.
// Register array with fall-through head; depends on nothing.
`default_nettype none
module erot_fifo #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4,
    localparam int PW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head_data,
    output logic                  full,
    output logic                  not_empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign head_data = mem_reg[rd_ptr_reg];
    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("queue underflow");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost an item");
`endif

endmodule
`default_nettype wire

FILE: rtl/erot_mac.sv
// Back end: nine coefficient-by-coordinate products, row sums, round and saturate.
// Three register stages that advance together; depends on erot_pkg.
`default_nettype none
module erot_mac
    import erot_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int CFW           = COEF_FRAC_BITS + 2,
    localparam int PW            = CFW + COORD_WIDTH,
    localparam int SW            = PW + 2
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [COEF_COUNT*CFW-1:0]    coefs,
    input  wire logic                         in_valid,
    input  wire logic [3*COORD_WIDTH-1:0]     in_data,
    output logic                              in_pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [3*COORD_WIDTH-1:0]          out_data,
    output logic                              out_clipped
);

    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -(SW'(1) <<< (COORD_WIDTH - 1));

    logic                          advance;
    logic                          v1_reg, v2_reg, out_valid_reg;
    logic signed [PW-1:0]          p_reg [COEF_COUNT];
    logic signed [PW-1:0]          p_next [COEF_COUNT];
    logic signed [SW-1:0]          s_reg [3];
    logic signed [SW-1:0]          s_next [3];
    logic [3*COORD_WIDTH-1:0]      res_reg, res_next;
    logic                          clip_reg, clip_next;
    logic signed [COORD_WIDTH-1:0] coord [3];
    logic signed [CFW-1:0]         coef [COEF_COUNT];
    logic signed [SW-1:0]          rnd [3];

    assign advance = !out_valid_reg || out_ready;
    assign in_pop  = advance && in_valid;

    always_comb begin
        for (int c = 0; c < 3; c++) coord[c] = $signed(in_data[c*COORD_WIDTH +: COORD_WIDTH]);
        for (int k = 0; k < COEF_COUNT; k++) begin
            coef[k]   = $signed(coefs[k*CFW +: CFW]);
            p_next[k] = coef[k] * coord[k % 3];
        end
        for (int r = 0; r < 3; r++) begin
            s_next[r] = SW'(p_reg[3*r]) + SW'(p_reg[3*r+1]) + SW'(p_reg[3*r+2]);
        end
        clip_next = 1'b0;
        res_next  = '0;
        for (int r = 0; r < 3; r++) begin
            rnd[r] = (s_reg[r] + HALF) >>> COEF_FRAC_BITS;
            if (rnd[r] > MAXV) begin
                res_next[r*COORD_WIDTH +: COORD_WIDTH] = COORD_WIDTH'(MAXV);
                clip_next = 1'b1;
            end else if (rnd[r] < MINV) begin
                res_next[r*COORD_WIDTH +: COORD_WIDTH] = COORD_WIDTH'(MINV);
                clip_next = 1'b1;
            end else begin
                res_next[r*COORD_WIDTH +: COORD_WIDTH] = COORD_WIDTH'(rnd[r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p_reg    <= p_next;
            s_reg    <= s_next;
            res_reg  <= res_next;
            clip_reg <= clip_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = res_reg;
    assign out_clipped = clip_reg;

endmodule
`default_nettype wire

FILE: tb/sv/tb_euler_point_rotator_top.sv
// Testbench for euler_point_rotator_top: streams points through ZXZ rotations,
// predicts each rotated point with a CORDIC-based matrix model, checks results in order.
// Depends on erot_pkg and the rotator RTL.
`default_nettype none
module tb_euler_point_rotator_top
    import erot_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_WIDTH_DEF;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic signed [CW-1:0] PMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] PMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 clip;
    } rotated_t;

    class rotation_board;
        longint atan_tab[CORDIC_STEPS] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
            41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
            10, 5, 3, 1};
        logic [15:0] angles[3];
        longint coef[9];
        rotated_t pending[$];
        int fails;

        function new();
            angles = '{16'd0, 16'd0, 16'd0};
            fails = 0;
            rebuild();
        endfunction

        function longint rnd(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function void sincos(logic [15:0] a, output longint c, output longint s);
            logic [31:0] turn;
            longint x, y, z, dx, dy;
            turn = {a, 16'd0};
            z = longint'(turn[29:0]);
            x = CORDIC_ONE;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end else begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
            end
            case (turn[31:30])
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function void rebuild();
            longint cp, sp, ct, st, cs, ss, sct, cct, v;
            longint m[9];
            longint one;
            one = longint'(1) <<< COEF_FRAC_BITS_DEF;
            sincos(angles[REG_FIRST_SPIN], cp, sp);
            sincos(angles[REG_TILT], ct, st);
            sincos(angles[REG_LAST_SPIN], cs, ss);
            sct = rnd(ss * ct, 30);
            cct = rnd(cs * ct, 30);
            m[0] = cs * cp - sct * sp;
            m[1] = -(cs * sp) - sct * cp;
            m[2] = ss * st;
            m[3] = ss * cp + cct * sp;
            m[4] = -(ss * sp) + cct * cp;
            m[5] = -(cs * st);
            m[6] = st * sp;
            m[7] = st * cp;
            m[8] = ct * (longint'(1) <<< 30);
            for (int k = 0; k < 9; k++) begin
                v = rnd(m[k], 60 - COEF_FRAC_BITS_DEF);
                coef[k] = v > one ? one : (v < -one ? -one : v);
            end
        endfunction

        function void set_angle(logic [1:0] idx, logic [15:0] a);
            if (idx == REG_UNUSED) return;
            angles[idx] = a;
            rebuild();
        endfunction

        function void note_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                 logic signed [CW-1:0] pz);
            longint p[3];
            longint v;
            longint hi, lo;
            rotated_t r;
            logic signed [CW-1:0] o[3];
            hi = (longint'(1) <<< (CW - 1)) - 1;
            lo = -(longint'(1) <<< (CW - 1));
            p[0] = px; p[1] = py; p[2] = pz;
            r.clip = 1'b0;
            for (int k = 0; k < 3; k++) begin
                v = rnd(coef[3*k] * p[0] + coef[3*k+1] * p[1] + coef[3*k+2] * p[2],
                        COEF_FRAC_BITS_DEF);
                if (v > hi) begin v = hi; r.clip = 1'b1; end
                if (v < lo) begin v = lo; r.clip = 1'b1; end
                o[k] = v[CW-1:0];
            end
            r.x = o[0]; r.y = o[1]; r.z = o[2];
            pending.push_back(r);
        endfunction

        function void report(string what);
            fails++;
            $display("mismatch at %0t: %s", $time, what);
        endfunction

        function void check_result(rotated_t got);
            rotated_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected item %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) report($sformatf("x got %0d want %0d", got.x, want.x));
            if (got.y !== want.y) report($sformatf("y got %0d want %0d", got.y, want.y));
            if (got.z !== want.z) report($sformatf("z got %0d want %0d", got.z, want.z));
            if (got.clip !== want.clip)
                report($sformatf("clipped got %0b want %0b", got.clip, want.clip));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [71:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic m_tuser;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    rotation_board board = new();
    int accepted_out = 0;

    always #4 aclk = ~aclk;

    euler_point_rotator_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                              logic signed [CW-1:0] pz);
        s_tvalid <= 1'b1;
        s_tdata <= {pz, py, px};
        do @(posedge aclk); while (!s_tready);
        board.note_point(px, py, pz);
    endtask

    task automatic pause_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain();
        pause_sender(1);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_angle(logic [1:0] idx, logic [15:0] a);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= a;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_angle(idx, a);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_rotation(logic [15:0] phi, logic [15:0] theta, logic [15:0] psi);
        drain();
        write_angle(REG_FIRST_SPIN, phi);
        write_angle(REG_TILT, theta);
        write_angle(REG_LAST_SPIN, psi);
    endtask

    function automatic logic signed [CW-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return PMAX;
            1: return PMIN;
            2: return '0;
            3: return CW'($urandom_range(0, 255)) - CW'(128);
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic random_points(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && n > 0) begin
                send_point(pick_coord(), pick_coord(), pick_coord());
                burst--;
                n--;
            end
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        end
    endtask

    // receiver: random stall pattern, one long hold-off while the sender keeps pushing
    initial begin
        int hold_done;
        hold_done = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                board.check_result({m_tdata[CW-1:0], m_tdata[2*CW-1:CW],
                                    m_tdata[3*CW-1:2*CW], m_tuser});
                accepted_out++;
            end
            if (!hold_done && accepted_out >= 60) begin
                hold_done = 1;
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
            end else if ((accepted_out / 64) % 3 == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        #5ms;
        $display("[euler_point_rotator_top] ERROR");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        send_point('0, '0, '0);
        send_point(PMAX, PMAX, PMAX);
        send_point(PMIN, PMIN, PMIN);
        send_point(PMAX, PMIN, CW'(1));
        send_point(CW'(-1), CW'(1), '1);
        set_rotation(16'd8192, 16'd0, 16'd0);
        send_point(PMAX, PMAX, '0);
        send_point(PMIN, PMIN, PMAX);
        send_point(PMAX, PMIN, PMIN);
        send_point(CW'(3), CW'(-5), CW'(7));
        set_rotation(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_point(PMAX, PMAX, PMAX);
        send_point(PMIN, PMAX, PMIN);
        set_rotation(16'h8000, 16'h4000, 16'hC000);
        send_point(PMAX, PMIN, PMAX);
        send_point(CW'(1), CW'(1), CW'(1));
        drain();
        write_angle(REG_UNUSED, 16'h1234);
        send_point(PMAX, CW'(12345), PMIN);
        random_points(140);
        set_rotation(16'd0, 16'd0, 16'd0);
        random_points(140);
        set_rotation(16'd8192, 16'd8192, 16'd8192);
        random_points(140);
        for (int ph = 0; ph < 4; ph++) begin
            set_rotation(16'($urandom), 16'($urandom), 16'($urandom));
            random_points(130);
        end
        drain();
        write_angle(REG_TILT, board.angles[REG_TILT]);
        random_points(140);
        drain();
        repeat (20) @(posedge aclk);
        if (board.pending.size() != 0) board.report("results never arrived");
        if (board.fails == 0) begin
            $display("[euler_point_rotator_top] OK");
        end else begin
            $display("[euler_point_rotator_top] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: euler_point_rotator_top.f
rtl/erot_pkg.sv
rtl/erot_coef.sv
rtl/erot_fifo.sv
rtl/erot_mac.sv
rtl/euler_point_rotator_top.sv
tb/sv/tb_euler_point_rotator_top.sv
